// File: hdl/jsu_pkg.sv
// Shared types, codes and decode functions for the JSON string unescaper.
`default_nettype none

package jsu_pkg;

   localparam int unsigned QueueDepth = 4;
   localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
   localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

   localparam logic [7:0] CH_NUL       = 8'h00;
   localparam logic [7:0] CH_QUOTE     = 8'h22;
   localparam logic [7:0] CH_BACKSLASH = 8'h5C;
   localparam logic [7:0] CH_SLASH     = 8'h2F;
   localparam logic [7:0] CH_LOWER_N   = 8'h6E;
   localparam logic [7:0] CH_LOWER_T   = 8'h74;
   localparam logic [7:0] CH_LOWER_R   = 8'h72;
   localparam logic [7:0] CH_LOWER_B   = 8'h62;
   localparam logic [7:0] CH_LOWER_F   = 8'h66;
   localparam logic [7:0] CH_LOWER_U   = 8'h75;

   localparam logic [15:0] CP_TWO_BYTE   = 16'h0080;
   localparam logic [15:0] CP_THREE_BYTE = 16'h0800;

   typedef enum logic [2:0] {
      ST_DATA    = 3'd0,
      ST_DONE    = 3'd1,
      ST_NOQUOTE = 3'd2,
      ST_BADESC  = 3'd3,
      ST_BADHEX  = 3'd4,
      ST_UNTERM  = 3'd5
   } status_type;

   typedef enum logic [3:0] {
      MODE_WAIT = 4'b0001,
      MODE_BODY = 4'b0010,
      MODE_ESC  = 4'b0100,
      MODE_HEX  = 4'b1000
   } mode_type;

   // One unit of work for the back end: a code point to encode, or a status.
   typedef struct packed {
      logic        is_status;
      status_type  status;
      logic [15:0] cp;
   } job_type;

   typedef struct packed {
      logic       valid;
      logic       is_u;
      logic [7:0] value;
   } esc_type;

   typedef struct packed {
      logic       valid;
      logic [3:0] value;
   } hex_type;

   function automatic hex_type hex_decode(input logic [7:0] c);
      hex_type h;
      h.valid = 1'b1;
      h.value = 4'h0;
      if (c >= 8'h30 && c <= 8'h39) begin
         h.value = c[3:0];
      end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
         h.value = c[3:0] + 4'd9;
      end else begin
         h.valid = 1'b0;
      end
      return h;
   endfunction

   function automatic esc_type esc_decode(input logic [7:0] c);
      esc_type e;
      e.valid = 1'b1;
      e.is_u  = 1'b0;
      e.value = 8'h00;
      unique case (c)
         CH_QUOTE:     e.value = CH_QUOTE;
         CH_BACKSLASH: e.value = CH_BACKSLASH;
         CH_SLASH:     e.value = CH_SLASH;
         CH_LOWER_N:   e.value = 8'h0A;
         CH_LOWER_T:   e.value = 8'h09;
         CH_LOWER_R:   e.value = 8'h0D;
         CH_LOWER_B:   e.value = 8'h08;
         CH_LOWER_F:   e.value = 8'h0C;
         CH_LOWER_U:   e.is_u  = 1'b1;
         default:      e.valid = 1'b0;
      endcase
      return e;
   endfunction

endpackage

`default_nettype wire

// File: hdl/jsu_front.sv
// Front end: accepts text bytes, tracks string mode and builds work items.
`default_nettype none

module jsu_front
   import jsu_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       accept,
   input  wire logic [7:0] in_byte,
   output logic            push,
   output job_type         push_job
);

   mode_type    mode_ff, mode_in;
   logic [1:0]  hex_count_ff, hex_count_in;
   logic [15:0] hex_accum_ff, hex_accum_in;
   logic [15:0] acc_next;
   hex_type     hex;
   esc_type     esc;

   assign hex      = hex_decode(in_byte);
   assign esc      = esc_decode(in_byte);
   assign acc_next = {hex_accum_ff[11:0], hex.value};

   always_comb begin
      mode_in      = mode_ff;
      hex_count_in = hex_count_ff;
      hex_accum_in = hex_accum_ff;
      push         = 1'b0;
      push_job     = '{is_status: 1'b0, status: ST_DATA, cp: 16'h0000};
      if (accept) begin
         unique case (mode_ff)
            MODE_WAIT: begin
               if (in_byte == CH_QUOTE) begin
                  mode_in = MODE_BODY;
               end else begin
                  push               = 1'b1;
                  push_job.is_status = 1'b1;
                  push_job.status    = ST_NOQUOTE;
               end
            end
            MODE_BODY: begin
               priority if (in_byte == CH_NUL) begin
                  mode_in            = MODE_WAIT;
                  push               = 1'b1;
                  push_job.is_status = 1'b1;
                  push_job.status    = ST_UNTERM;
               end else if (in_byte == CH_QUOTE) begin
                  mode_in            = MODE_WAIT;
                  push               = 1'b1;
                  push_job.is_status = 1'b1;
                  push_job.status    = ST_DONE;
               end else if (in_byte == CH_BACKSLASH) begin
                  mode_in = MODE_ESC;
               end else begin
                  push        = 1'b1;
                  push_job.cp = {8'h00, in_byte};
               end
            end
            MODE_ESC: begin
               priority if (esc.is_u) begin
                  mode_in      = MODE_HEX;
                  hex_count_in = 2'd0;
                  hex_accum_in = 16'h0000;
               end else if (esc.valid) begin
                  mode_in     = MODE_BODY;
                  push        = 1'b1;
                  push_job.cp = {8'h00, esc.value};
               end else begin
                  mode_in            = MODE_WAIT;
                  push               = 1'b1;
                  push_job.is_status = 1'b1;
                  push_job.status    = ST_BADESC;
               end
            end
            MODE_HEX: begin
               priority if (!hex.valid) begin
                  mode_in            = MODE_WAIT;
                  hex_count_in       = 2'd0;
                  hex_accum_in       = 16'h0000;
                  push               = 1'b1;
                  push_job.is_status = 1'b1;
                  push_job.status    = ST_BADHEX;
               end else if (hex_count_ff == 2'd3) begin
                  mode_in      = MODE_BODY;
                  hex_count_in = 2'd0;
                  hex_accum_in = 16'h0000;
                  push         = 1'b1;
                  push_job.cp  = acc_next;
               end else begin
                  hex_count_in = hex_count_ff + 2'd1;
                  hex_accum_in = acc_next;
               end
            end
            default: begin
               mode_in      = MODE_WAIT;
               hex_count_in = 2'd0;
               hex_accum_in = 16'h0000;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_WAIT;
         hex_count_ff <= 2'd0;
         hex_accum_ff <= 16'h0000;
      end else begin
         mode_ff      <= mode_in;
         hex_count_ff <= hex_count_in;
         hex_accum_ff <= hex_accum_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/jsu_queue.sv
// Short work-item queue between the front and back ends.
`default_nettype none

module jsu_queue
   import jsu_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     push,
   input  wire job_type  push_job,
   input  wire logic     pop,
   output logic          full,
   output logic          empty,
   output job_type       head_job
);

   job_type              mem_ff [QueueDepth];
   logic [QueuePtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QueueCntW-1:0] count_ff, count_in;

   assign full     = (count_ff == QueueCntW'(QueueDepth));
   assign empty    = (count_ff == '0);
   assign head_job = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) !(push && full))
      else $error("push into full queue");
   assert property (@(posedge clock) disable iff (reset) !(pop && empty))
      else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset)
      count_ff[QueuePtrW-1:0] == QueuePtrW'(wr_ptr_ff - rd_ptr_ff)
      && count_ff <= QueueCntW'(QueueDepth))
      else $error("queue count disagrees with pointers");

endmodule

`default_nettype wire

// File: hdl/jsu_back.sv
// Back end: expands work items into UTF-8 bytes and status words.
`default_nettype none

module jsu_back
   import jsu_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_empty,
   input  wire job_type q_head,
   output logic         q_pop,
   output logic         out_valid,
   input  wire logic    out_ready,
   output logic [7:0]   out_byte,
   output logic [2:0]   out_status,
   output logic         out_last
);

   logic       busy_ff, busy_in;
   job_type    job_ff, job_in;
   logic [1:0] idx_ff, idx_in;
   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   status_type status_ff, status_in;
   logic       last_ff, last_in;

   job_type    cur_job;
   logic [1:0] cur_idx;
   logic       have_job;
   logic       load;
   logic [1:0] final_idx;
   logic [7:0] cur_byte;
   logic       cur_last;

   assign load     = !valid_ff || out_ready;
   assign have_job = busy_ff || !q_empty;
   assign cur_job  = busy_ff ? job_ff : q_head;
   assign cur_idx  = busy_ff ? idx_ff : 2'd0;
   assign q_pop    = load && !busy_ff && !q_empty;

   always_comb begin
      if (cur_job.cp < CP_TWO_BYTE) begin
         final_idx = 2'd0;
      end else if (cur_job.cp < CP_THREE_BYTE) begin
         final_idx = 2'd1;
      end else begin
         final_idx = 2'd2;
      end
      cur_byte = 8'h00;
      unique case (final_idx)
         2'd0: cur_byte = cur_job.cp[7:0];
         2'd1: cur_byte = (cur_idx == 2'd0) ? {3'b110, cur_job.cp[10:6]}
                                            : {2'b10, cur_job.cp[5:0]};
         default: begin
            unique case (cur_idx)
               2'd0:    cur_byte = {4'b1110, cur_job.cp[15:12]};
               2'd1:    cur_byte = {2'b10, cur_job.cp[11:6]};
               default: cur_byte = {2'b10, cur_job.cp[5:0]};
            endcase
         end
      endcase
      if (cur_job.is_status) begin
         cur_byte = 8'h00;
         cur_last = 1'b1;
      end else begin
         cur_last = (cur_idx == final_idx);
      end
   end

   always_comb begin
      busy_in   = busy_ff;
      job_in    = job_ff;
      idx_in    = idx_ff;
      valid_in  = valid_ff;
      byte_in   = byte_ff;
      status_in = status_ff;
      last_in   = last_ff;
      if (load) begin
         valid_in = have_job;
         if (have_job) begin
            byte_in   = cur_byte;
            status_in = cur_job.is_status ? cur_job.status : ST_DATA;
            last_in   = cur_last;
            busy_in   = !cur_last;
            job_in    = cur_job;
            idx_in    = cur_idx + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         idx_ff   <= 2'd0;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff    <= job_in;
      byte_ff   <= byte_in;
      status_ff <= status_in;
      last_ff   <= last_in;
   end

   assign out_valid  = valid_ff;
   assign out_byte   = byte_ff;
   assign out_status = status_ff;
   assign out_last   = last_ff;

   assert property (@(posedge clock) disable iff (reset) busy_ff |-> idx_ff != 2'd0)
      else $error("multi-byte item in progress with zero byte index");
   assert property (@(posedge clock) disable iff (reset) busy_ff |-> !job_ff.is_status)
      else $error("status item left in progress");
   assert property (@(posedge clock) disable iff (reset)
      (valid_ff && status_ff != ST_DATA) |-> (last_ff && byte_ff == 8'h00))
      else $error("status word not marked last with zero byte");

endmodule

`default_nettype wire

// File: hdl/json_string_unescape_utf8_core.sv
// Top level of the streaming JSON string unescaper with UTF-8 output.
// An accepted byte's item is queued, then its first word is registered at the output.
// Throughput: one input byte per cycle while the 4-entry work queue has room; an
//   item giving k result words holds the output stage until all k are taken.
// Reset (synchronous, active high): mode back to waiting for the opening quote,
//   hex state cleared, work queue and output stage emptied.
`default_nettype none

module json_string_unescape_utf8_core
   import jsu_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   // input text bytes
   input  wire logic       req_tvalid,
   output logic            req_tready,
   input  wire logic [7:0] req_tdata,   // [7:0] in_byte
   // decoded result words
   output logic            rsp_tvalid,
   input  wire logic       rsp_tready,
   output logic [7:0]      rsp_tdata,   // [7:0] out_byte
   output logic [2:0]      rsp_tuser,   // [2:0] status
   output logic            rsp_tlast    // last word caused by one input byte
);

   logic    accept;
   logic    push;
   job_type push_job;
   logic    pop;
   logic    q_full;
   logic    q_empty;
   job_type head_job;

   // Take a byte whenever the queue has room, even if it produces no word.
   assign req_tready = !q_full;
   assign accept     = req_tvalid && req_tready;

   // Front: string mode, escapes and hex digits; emits one work item per result group.
   jsu_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .in_byte  (req_tdata),
      .push     (push),
      .push_job (push_job)
   );

   // Queue decouples byte intake from multi-word output.
   jsu_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .full     (q_full),
      .empty    (q_empty),
      .head_job (head_job)
   );

   // Back: encode code points as 1 to 3 UTF-8 bytes, or pass a status word.
   jsu_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_empty    (q_empty),
      .q_head     (head_job),
      .q_pop      (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_byte   (rsp_tdata),
      .out_status (rsp_tuser),
      .out_last   (rsp_tlast)
   );

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// Self-checking testbench for the streaming JSON string unescaper with UTF-8 output.
`timescale 1ns / 100ps

module tb_top
   import jsu_pkg::*;
;

   // One decoded result word as it leaves the block.
   typedef struct packed {
      logic [7:0] out_byte;
      status_type status;
      logic       last;
   } decoded_word_type;

   logic       clock      = 1'b0;
   logic       reset      = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = 8'h00;   // [7:0] in_byte
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;            // [7:0] out_byte
   logic [2:0] rsp_tuser;            // [2:0] status
   logic       rsp_tlast;            // last word caused by one input byte

   json_string_unescape_utf8_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // 8 ns period
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Text bytes still to be sent, and decoded words still to arrive.
   logic [7:0]       text_bytes[$];
   decoded_word_type expected_words[$];

   // Shadow decoder state.
   mode_type    text_mode = MODE_WAIT;
   logic [1:0]  hex_count = 2'd0;
   logic [15:0] hex_accum = 16'h0000;

   int error_count    = 0;
   int bytes_accepted = 0;
   int words_checked  = 0;
   int strings_closed = 0;
   int error_reports  = 0;
   int multi_byte     = 0;

   // ---------------------------------------------------------------------
   // Shadow decoder
   // ---------------------------------------------------------------------

   // Hex digit value, or 16 when the byte is not a hex digit.
   function automatic logic [4:0] hex_digit_of(input logic [7:0] c);
      if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
      if (c >= 8'h61 && c <= 8'h66) return 5'(c - 8'h61 + 8'd10);
      if (c >= 8'h41 && c <= 8'h46) return 5'(c - 8'h41 + 8'd10);
      return 5'd16;
   endfunction

   // Bit 8 set when c names a one-byte escape; bits 7:0 hold the byte it stands for.
   function automatic logic [8:0] escape_value(input logic [7:0] c);
      case (c)
         CH_QUOTE:     return {1'b1, CH_QUOTE};
         CH_BACKSLASH: return {1'b1, CH_BACKSLASH};
         CH_SLASH:     return {1'b1, CH_SLASH};
         CH_LOWER_N:   return {1'b1, 8'h0A};
         CH_LOWER_T:   return {1'b1, 8'h09};
         CH_LOWER_R:   return {1'b1, 8'h0D};
         CH_LOWER_B:   return {1'b1, 8'h08};
         CH_LOWER_F:   return {1'b1, 8'h0C};
         default:      return 9'h000;
      endcase
   endfunction

   task automatic push_word(input logic [7:0] b, input status_type st, input logic last);
      decoded_word_type w;
      w.out_byte = b;
      w.status   = st;
      w.last     = last;
      expected_words.push_back(w);
   endtask

   // Status words carry a zero byte and always close the item.
   task automatic push_status(input status_type st);
      push_word(8'h00, st, 1'b1);
   endtask

   task automatic push_utf8(input logic [15:0] cp);
      if (cp < CP_TWO_BYTE) begin
         push_word(cp[7:0], ST_DATA, 1'b1);
      end else if (cp < CP_THREE_BYTE) begin
         push_word({3'b110, cp[10:6]}, ST_DATA, 1'b0);
         push_word({2'b10, cp[5:0]}, ST_DATA, 1'b1);
      end else begin
         push_word({4'b1110, cp[15:12]}, ST_DATA, 1'b0);
         push_word({2'b10, cp[11:6]}, ST_DATA, 1'b0);
         push_word({2'b10, cp[5:0]}, ST_DATA, 1'b1);
      end
   endtask

   // Advance the shadow decoder by one accepted text byte.
   task automatic decode_byte(input logic [7:0] c);
      logic [4:0] nib;
      logic [8:0] esc;
      nib = hex_digit_of(c);
      esc = escape_value(c);
      case (text_mode)
         MODE_WAIT: begin
            if (c == CH_QUOTE) text_mode = MODE_BODY;
            else push_status(ST_NOQUOTE);
         end
         MODE_BODY: begin
            if (c == CH_NUL) begin
               text_mode = MODE_WAIT;
               push_status(ST_UNTERM);
            end else if (c == CH_QUOTE) begin
               text_mode = MODE_WAIT;
               push_status(ST_DONE);
            end else if (c == CH_BACKSLASH) begin
               text_mode = MODE_ESC;
            end else begin
               push_utf8({8'h00, c});
            end
         end
         MODE_ESC: begin
            if (esc[8]) begin
               text_mode = MODE_BODY;
               push_utf8({8'h00, esc[7:0]});
            end else if (c == CH_LOWER_U) begin
               text_mode = MODE_HEX;
               hex_count = 2'd0;
               hex_accum = 16'h0000;
            end else begin
               text_mode = MODE_WAIT;
               push_status(ST_BADESC);
            end
         end
         default: begin
            if (nib[4]) begin
               text_mode = MODE_WAIT;
               hex_count = 2'd0;
               hex_accum = 16'h0000;
               push_status(ST_BADHEX);
            end else begin
               hex_accum = {hex_accum[11:0], nib[3:0]};
               if (hex_count == 2'd3) begin
                  text_mode = MODE_BODY;
                  push_utf8(hex_accum);
                  hex_count = 2'd0;
                  hex_accum = 16'h0000;
               end else begin
                  hex_count = hex_count + 2'd1;
               end
            end
         end
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Stimulus building
   // ---------------------------------------------------------------------

   task automatic add_byte(input logic [7:0] b);
      text_bytes.push_back(b);
   endtask

   function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit upper);
      if (nib < 4'd10) return 8'h30 + {4'h0, nib};
      return (upper ? 8'h41 : 8'h61) + {4'h0, nib} - 8'd10;
   endfunction

   // Append \uXXXX with a random letter case per digit.
   task automatic add_hex_escape(input logic [15:0] cp);
      int i;
      add_byte(CH_BACKSLASH);
      add_byte(CH_LOWER_U);
      for (i = 3; i >= 0; i--) add_byte(hex_char(cp[i*4 +: 4], $urandom_range(0, 1) == 1));
   endtask

   // Mostly well-formed strings with random content; some noise ahead of
   // the quote and some broken endings.
   task automatic add_random_string();
      int         pieces;
      int         i;
      int         k;
      logic [7:0] b;
      logic [8:0] esc;
      logic [4:0] nib;
      if ($urandom_range(0, 7) == 0) begin
         k = $urandom_range(1, 3);
         for (i = 0; i < k; i++) begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_QUOTE);
            add_byte(b);
         end
      end
      add_byte(CH_QUOTE);
      pieces = $urandom_range(0, 8);
      for (i = 0; i < pieces; i++) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
               do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE || b == CH_BACKSLASH);
               add_byte(b);
            end
            5, 6: begin
               add_byte(CH_BACKSLASH);
               case ($urandom_range(0, 7))
                  0: add_byte(CH_QUOTE);
                  1: add_byte(CH_BACKSLASH);
                  2: add_byte(CH_SLASH);
                  3: add_byte(CH_LOWER_N);
                  4: add_byte(CH_LOWER_T);
                  5: add_byte(CH_LOWER_R);
                  6: add_byte(CH_LOWER_B);
                  default: add_byte(CH_LOWER_F);
               endcase
            end
            default: begin
               case ($urandom_range(0, 2))
                  0: add_hex_escape(16'($urandom_range(16'h0000, 16'h007F)));
                  1: add_hex_escape(16'($urandom_range(16'h0080, 16'h07FF)));
                  default: add_hex_escape(16'($urandom_range(16'h0800, 16'hFFFF)));
               endcase
            end
         endcase
      end
      case ($urandom_range(0, 9))
         7: add_byte(CH_NUL);
         8: begin
            // unknown escape, NUL included
            add_byte(CH_BACKSLASH);
            do begin
               b   = 8'($urandom_range(0, 255));
               esc = escape_value(b);
            end while (esc[8] || b == CH_LOWER_U);
            add_byte(b);
         end
         9: begin
            // cut a \u sequence short with a non-hex byte
            add_byte(CH_BACKSLASH);
            add_byte(CH_LOWER_U);
            k = $urandom_range(0, 3);
            for (i = 0; i < k; i++) add_byte(hex_char(4'($urandom_range(0, 15)), 1'b0));
            do begin
               b   = 8'($urandom_range(0, 255));
               nib = hex_digit_of(b);
            end while (!nib[4]);
            add_byte(b);
         end
         default: add_byte(CH_QUOTE);
      endcase
   endtask

   // ---------------------------------------------------------------------
   // Driver: bursts of random length separated by random gaps
   // ---------------------------------------------------------------------
   int burst_left = 0;
   int gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tdata  <= 8'h00;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            decode_byte(req_tdata);
            bytes_accepted++;
         end
         // Load the next word only once the current one has gone.
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
               req_tdata  <= 8'($urandom_range(0, 255));
            end else if (text_bytes.size() > 0) begin
               req_tvalid <= 1'b1;
               req_tdata  <= text_bytes.pop_front();
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end else begin
                  burst_left--;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Receiver stall pattern: cycle through always ready, coin flip,
   // one cycle in four, and mostly ready.
   // ---------------------------------------------------------------------
   logic [9:0] stall_tick = 10'd0;

   always @(posedge clock) begin
      if (reset) begin
         stall_tick <= 10'd0;
         rsp_tready <= 1'b0;
      end else begin
         stall_tick <= stall_tick + 10'd1;
         case (stall_tick[8:7])
            2'd0: rsp_tready <= 1'b1;
            2'd1: rsp_tready <= ($urandom_range(0, 1) == 1);
            2'd2: rsp_tready <= (stall_tick[1:0] == 2'd0);
            default: rsp_tready <= ($urandom_range(0, 4) != 0);
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: compare each result word with the oldest expectation
   // ---------------------------------------------------------------------
   decoded_word_type want;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (rsp_tuser == ST_DONE) strings_closed++;
         else if (rsp_tuser != ST_DATA) error_reports++;
         if (rsp_tuser == ST_DATA && !rsp_tlast) multi_byte++;
         if (expected_words.size() == 0) begin
            error_count++;
            $display("%0t: unexpected word: out_byte %h status %0d last %b",
                     $realtime, rsp_tdata, rsp_tuser, rsp_tlast);
         end else begin
            want = expected_words.pop_front();
            if (rsp_tdata !== want.out_byte) begin
               error_count++;
               $display("%0t: word %0d out_byte: expected %h actual %h",
                        $realtime, words_checked, want.out_byte, rsp_tdata);
            end
            if (rsp_tuser !== want.status) begin
               error_count++;
               $display("%0t: word %0d status: expected %0d actual %0d",
                        $realtime, words_checked, want.status, rsp_tuser);
            end
            if (rsp_tlast !== want.last) begin
               error_count++;
               $display("%0t: word %0d last: expected %b actual %b",
                        $realtime, words_checked, want.last, rsp_tlast);
            end
         end
         words_checked++;
      end
   end

   // ---------------------------------------------------------------------
   // Stimulus, reset and end of run
   // ---------------------------------------------------------------------
   initial begin
      int directed_len;

      // Directed: wrong first bytes (NUL too), raw ASCII extremes, raw high
      // bytes, a simple escape, \u0000 and \uFFFF, then each error ending.
      add_byte(8'h78);
      add_byte(CH_NUL);
      add_byte(CH_QUOTE);
      add_byte(8'h01);
      add_byte(8'h7F);
      add_byte(8'h80);
      add_byte(8'hFF);
      add_byte(CH_BACKSLASH);
      add_byte(CH_LOWER_N);
      add_hex_escape(16'h0000);
      add_hex_escape(16'hFFFF);
      add_byte(CH_QUOTE);
      add_byte(CH_QUOTE);
      add_byte(CH_BACKSLASH);
      add_byte(8'h71);
      add_byte(CH_QUOTE);
      add_byte(CH_BACKSLASH);
      add_byte(CH_LOWER_U);
      add_byte(8'h67);
      add_byte(CH_QUOTE);
      add_byte(CH_NUL);
      directed_len = text_bytes.size();

      while (text_bytes.size() < directed_len + 285) add_random_string();

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Hold until every text word has been taken, then drain the results.
      while (text_bytes.size() != 0 || req_tvalid) @(posedge clock);
      while (expected_words.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);

      $display("covered %0d text bytes, %0d result words (%0d inside multi-byte sequences)",
               bytes_accepted, words_checked, multi_byte);
      $display("strings closed: %0d, error reports: %0d", strings_closed, error_reports);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest legal run.
   initial begin
      #2_000_000;
      $display("timeout waiting for the run to drain");
      $display("status: fail");
      $finish;
   end

endmodule
